// File: design/phe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package phe_pkg;

    // Highest power of x taken into the evaluation.
    localparam int MAX_DEGREE = 7;
    // Number of coefficient registers.
    localparam int NUM_COEF   = 8;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);
    // Configuration index is wider than needed so that writes past the list can be seen.
    localparam int CFG_IDX_W  = COEF_IDX_W + 1;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    // Running state of one item as it moves down the pipeline.
    typedef struct packed {
        word_t acc;
        word_t x;
        logic  ovf;
    } horner_t;

endpackage

`default_nettype wire

// File: design/phe_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface phe_sample_if import phe_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

`default_nettype wire

// File: design/phe_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface phe_result_if import phe_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t poly_value;
    logic  overflow;

    modport source (output valid, output poly_value, output overflow, input ready);
    modport sink   (input valid, input poly_value, input overflow, output ready);
endinterface

`default_nettype wire

// File: design/phe_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface phe_cfg_if import phe_pkg::*; ();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    word_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/phe_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One Horner step in two register stages: multiply, then scale, add and saturate.
module phe_step import phe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  word_t   coef,
    input  logic    in_valid,
    output logic    in_ready,
    input  horner_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output horner_t out_data
);

    logic    a_valid_reg;
    prod_t   prod_reg;
    word_t   x_reg;
    logic    ovf_reg;
    logic    a_ready;
    prod_t   prod_next;

    logic    b_valid_reg;
    horner_t b_data_reg;
    horner_t b_data_next;
    logic    b_ready;

    prod_t                shifted;
    logic                 shift_sat;
    word_t                scaled;
    logic signed [DATA_W:0] sum;
    logic                 sum_sat;

    // Each stage moves when it is empty or its successor moves.
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign prod_next = in_data.acc * in_data.x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            prod_reg <= prod_next;
            x_reg    <= in_data.x;
            ovf_reg  <= in_data.ovf;
        end
    end

    // Arithmetic shift is floor division by 2^FRAC_W.
    always_comb
    begin
        shifted   = prod_reg >>> FRAC_W;
        shift_sat = !((&shifted[PROD_W-1:DATA_W-1]) || !(|shifted[PROD_W-1:DATA_W-1]));
        if (!shift_sat)
        begin
            scaled = shifted[DATA_W-1:0];
        end
        else if (shifted[PROD_W-1])
        begin
            scaled = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            scaled = {1'b0, {(DATA_W-1){1'b1}}};
        end

        sum     = {scaled[DATA_W-1], scaled} + {coef[DATA_W-1], coef};
        sum_sat = sum[DATA_W] != sum[DATA_W-1];

        b_data_next.x   = x_reg;
        b_data_next.ovf = ovf_reg || shift_sat || sum_sat;
        if (!sum_sat)
        begin
            b_data_next.acc = sum[DATA_W-1:0];
        end
        else if (sum[DATA_W])
        begin
            b_data_next.acc = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            b_data_next.acc = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

// File: design/polynomial_horner_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                          Accepted when
// --------  ---------  -------------------------------  ---------------------
// sample    in         x_value (signed Q16.16)          valid && ready
// result    out        poly_value (Q16.16), overflow    valid && ready
// cfg       in         index, data (coefficient write)  valid && ready (ready = 1)
//
// One word enters per cycle unless the result side stalls a full pipe; the path is one input
// register plus two stages (multiplier, then scale/add/saturate) per Horner step.
// Reset clears all coefficients to zero and empties the pipeline.
// Each stage holds its word while the next one is full and stalled; empty stages
// keep filling, so a stalled result does not block intake until the pipe is full.
module polynomial_horner_eval import phe_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    phe_sample_if.sink    sample,
    phe_result_if.source  result,
    phe_cfg_if.sink       cfg
);

    // Coefficient registers, written from the configuration channel.
    word_t   coef_reg [NUM_COEF];

    // Pipeline links: link 0 is the input register, link MAX_DEGREE the output register.
    logic    link_valid [MAX_DEGREE+1];
    logic    link_ready [MAX_DEGREE+1];
    horner_t link_data  [MAX_DEGREE+1];

    logic    in_valid_reg;
    horner_t in_data_reg;
    logic    in_ready;

    // Configuration writes are registered; indexes past the list are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg.valid && (cfg.index < CFG_IDX_W'(NUM_COEF)))
        begin
            coef_reg[cfg.index[COEF_IDX_W-1:0]] <= cfg.data;
        end
    end

    // Input register. The top step starts from zero, so its result is the
    // leading coefficient itself with no saturation: seed it directly.
    assign in_ready     = !in_valid_reg || link_ready[0];
    assign sample.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && sample.valid)
        begin
            in_data_reg.acc <= coef_reg[MAX_DEGREE];
            in_data_reg.x   <= sample.x_value;
            in_data_reg.ovf <= 1'b0;
        end
    end

    assign link_valid[0] = in_valid_reg;
    assign link_data[0]  = in_data_reg;

    // Remaining Horner steps, highest remaining coefficient first.
    for (genvar j = 0; j < MAX_DEGREE; j++)
    begin : g_step
        localparam int CoefIdx = MAX_DEGREE - 1 - j;

        phe_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .coef      (coef_reg[CoefIdx]),
            .in_valid  (link_valid[j]),
            .in_ready  (link_ready[j]),
            .in_data   (link_data[j]),
            .out_valid (link_valid[j+1]),
            .out_ready (link_ready[j+1]),
            .out_data  (link_data[j+1])
        );
    end

    // The last step's second stage is the output register.
    assign link_ready[MAX_DEGREE] = result.ready;
    assign result.valid           = link_valid[MAX_DEGREE];
    assign result.poly_value      = link_data[MAX_DEGREE].acc;
    assign result.overflow        = link_data[MAX_DEGREE].ovf;

endmodule

`default_nettype wire
